// ----- hdl/ppa_pkg.sv -----
// ppa_pkg: shared constants, codes and types of the port pool allocator.
// No dependencies; used by ppa_ctrl and port_pool_allocator.
`timescale 1ns / 1ps

package ppa_pkg;

  localparam int PORT_W = 16;
  localparam int CNT_W  = 32;
  localparam int STAT_W = 32;

  localparam logic [PORT_W-1:0] PORT_MAX    = {PORT_W{1'b1}};
  localparam logic [PORT_W-1:0] FIRST_RESET = 16'd49152;
  localparam logic [PORT_W-1:0] LAST_RESET  = 16'd65535;

  // status marks; anything else is the counter value at which the port was pushed
  localparam logic [STAT_W-1:0] MARK_OOR    = 32'hFFFF_FFFF;
  localparam logic [STAT_W-1:0] MARK_SINGLE = 32'hFFFF_FFFE;
  localparam logic [STAT_W-1:0] MARK_EVEN   = 32'hFFFF_FFFD;
  localparam logic [STAT_W-1:0] MARK_ODD    = 32'hFFFF_FFFC;

  typedef enum logic [2:0] {
    FN_ALLOC      = 3'd0,
    FN_ALLOC_EVEN = 3'd1,
    FN_RELEASE    = 3'd2,
    FN_QRY_ALLOC  = 3'd3,
    FN_QRY_AVAIL  = 3'd4
  } func_t;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_LAST  = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POP_CHK,
    ST_POP_RING,
    ST_POP_STAT,
    ST_EVEN_NEXT,
    ST_PAIR_STAT,
    ST_PAIR_RING,
    ST_PAIR_ODD,
    ST_REL_STAT,
    ST_QRY_STAT,
    ST_QRY_RING,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PORT_W-1:0] addr;
    logic [PORT_W-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic              we;
    logic [PORT_W-1:0] addr;
    logic [STAT_W-1:0] wdata;
  } stat_req_t;

  function automatic logic taken_mark(input logic [STAT_W-1:0] s);
    return (s == MARK_SINGLE) || (s == MARK_EVEN) || (s == MARK_ODD);
  endfunction

endpackage

// ----- hdl/ppa_ram.sv -----
// ppa_ram: generic single-port RAM, one access a cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ppa_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 16
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/ppa_ctrl.sv -----
// ppa_ctrl: sequencer, counters, config and result registers of the allocator.
// Depends on ppa_pkg; drives the ring and status RAM ports.
`timescale 1ns / 1ps

module ppa_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [ppa_pkg::PORT_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_func,
  input  logic [ppa_pkg::PORT_W-1:0] in_port_number,
  input  logic                      in_want_pair,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_outcome,
  output logic [ppa_pkg::PORT_W-1:0] out_granted_port,
  output logic                      out_answer,
  output ppa_pkg::ring_req_t        ring_req,
  input  logic [ppa_pkg::PORT_W-1:0] ring_q,
  output ppa_pkg::stat_req_t        stat_req,
  input  logic [ppa_pkg::STAT_W-1:0] stat_q
);

  ppa_pkg::state_t state_r, state_nxt;

  logic [ppa_pkg::PORT_W-1:0] first_r, first_nxt, last_r, last_nxt;
  logic [ppa_pkg::CNT_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [ppa_pkg::CNT_W-1:0]  size_r, size_nxt, iter_r, iter_nxt;
  logic [ppa_pkg::PORT_W-1:0] clr_r, clr_nxt;
  logic [2:0]                 func_r, func_nxt;
  logic [ppa_pkg::PORT_W-1:0] port_r, port_nxt, cand_r, cand_nxt;
  logic                       pair_r, pair_nxt;
  logic                       res_fail_r, res_fail_nxt, res_ans_r, res_ans_nxt;
  logic [ppa_pkg::PORT_W-1:0] res_port_r, res_port_nxt;
  logic                       ov_r, ov_nxt, oo_r, oo_nxt, oa_r, oa_nxt;
  logic [ppa_pkg::PORT_W-1:0] op_r, op_nxt;

  logic                       pool_empty, out_free;
  logic [ppa_pkg::PORT_W-1:0] partner;
  logic [ppa_pkg::CNT_W-1:0]  span;

  function automatic logic in_pool(input logic [ppa_pkg::PORT_W-1:0] p,
                                   input logic [ppa_pkg::PORT_W-1:0] lo,
                                   input logic [ppa_pkg::PORT_W-1:0] hi);
    return (lo <= hi) && (p >= lo) && (p <= hi);
  endfunction

  assign pool_empty = first_r > last_r;
  assign partner    = cand_r + 16'd1;
  assign span       = tail_r - head_r;
  assign out_free   = !ov_r || !out_stall;
  assign in_stall   = (state_r != ppa_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ppa_pkg::ST_CLEAR: begin
        if (clr_r == ppa_pkg::PORT_MAX) begin
          state_nxt = ppa_pkg::ST_IDLE;
        end
      end
      ppa_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (in_func)
            ppa_pkg::FN_ALLOC: state_nxt = ppa_pkg::ST_POP_CHK;
            ppa_pkg::FN_ALLOC_EVEN: begin
              if (tail_r <= head_r || span <= 32'd1) begin
                state_nxt = ppa_pkg::ST_DONE;
              end else begin
                state_nxt = ppa_pkg::ST_POP_CHK;
              end
            end
            ppa_pkg::FN_RELEASE: state_nxt = ppa_pkg::ST_REL_STAT;
            ppa_pkg::FN_QRY_ALLOC, ppa_pkg::FN_QRY_AVAIL: state_nxt = ppa_pkg::ST_QRY_STAT;
            default: state_nxt = ppa_pkg::ST_DONE;
          endcase
        end
      end
      ppa_pkg::ST_POP_CHK: begin
        state_nxt = (tail_r <= head_r) ? ppa_pkg::ST_DONE : ppa_pkg::ST_POP_RING;
      end
      ppa_pkg::ST_POP_RING: begin
        state_nxt = in_pool(ring_q, first_r, last_r) ? ppa_pkg::ST_POP_STAT
                                                     : ppa_pkg::ST_DONE;
      end
      ppa_pkg::ST_POP_STAT: begin
        if (ppa_pkg::taken_mark(stat_q) || stat_q != head_r) begin
          state_nxt = ppa_pkg::ST_POP_CHK;
        end else if (func_r == ppa_pkg::FN_ALLOC) begin
          state_nxt = ppa_pkg::ST_DONE;
        end else begin
          state_nxt = ppa_pkg::ST_EVEN_NEXT;
        end
      end
      ppa_pkg::ST_EVEN_NEXT: begin
        if (!cand_r[0] && !pair_r) begin
          state_nxt = ppa_pkg::ST_DONE;
        end else if (!cand_r[0] && partner <= last_r) begin
          state_nxt = ppa_pkg::ST_PAIR_STAT;
        end else begin
          state_nxt = (iter_r + 32'd1 < size_r) ? ppa_pkg::ST_POP_CHK : ppa_pkg::ST_DONE;
        end
      end
      ppa_pkg::ST_PAIR_STAT: begin
        if (stat_q == ppa_pkg::MARK_OOR || ppa_pkg::taken_mark(stat_q)) begin
          state_nxt = (iter_r + 32'd1 < size_r) ? ppa_pkg::ST_POP_CHK : ppa_pkg::ST_DONE;
        end else begin
          state_nxt = ppa_pkg::ST_PAIR_RING;
        end
      end
      ppa_pkg::ST_PAIR_RING: begin
        if (ring_q == partner) begin
          state_nxt = ppa_pkg::ST_PAIR_ODD;
        end else begin
          state_nxt = (iter_r + 32'd1 < size_r) ? ppa_pkg::ST_POP_CHK : ppa_pkg::ST_DONE;
        end
      end
      ppa_pkg::ST_PAIR_ODD: state_nxt = ppa_pkg::ST_DONE;
      ppa_pkg::ST_REL_STAT: state_nxt = ppa_pkg::ST_DONE;
      ppa_pkg::ST_QRY_STAT: begin
        if (func_r == ppa_pkg::FN_QRY_AVAIL && stat_q != ppa_pkg::MARK_OOR &&
            !ppa_pkg::taken_mark(stat_q)) begin
          state_nxt = ppa_pkg::ST_QRY_RING;
        end else begin
          state_nxt = ppa_pkg::ST_DONE;
        end
      end
      ppa_pkg::ST_QRY_RING: state_nxt = ppa_pkg::ST_DONE;
      ppa_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = ppa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppa_pkg::ST_CLEAR;
    endcase
    if (cfg_wr_en) begin
      state_nxt = ppa_pkg::ST_CLEAR;
    end
  end

  // datapath and memory ports
  always_comb begin
    first_nxt    = first_r;
    last_nxt     = last_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    size_nxt     = size_r;
    iter_nxt     = iter_r;
    clr_nxt      = clr_r;
    func_nxt     = func_r;
    port_nxt     = port_r;
    pair_nxt     = pair_r;
    cand_nxt     = cand_r;
    res_fail_nxt = res_fail_r;
    res_port_nxt = res_port_r;
    res_ans_nxt  = res_ans_r;
    ov_nxt       = ov_r && out_stall;
    oo_nxt       = oo_r;
    op_nxt       = op_r;
    oa_nxt       = oa_r;
    ring_req     = '{we: 1'b0, addr: head_r[ppa_pkg::PORT_W-1:0], wdata: cand_r};
    stat_req     = '{we: 1'b0, addr: cand_r, wdata: tail_r};

    unique case (state_r)
      ppa_pkg::ST_CLEAR: begin
        ring_req = '{we: 1'b1, addr: clr_r, wdata: clr_r};
        stat_req = '{we: 1'b1, addr: clr_r,
                     wdata: in_pool(clr_r, first_r, last_r) ?
                            {{(ppa_pkg::STAT_W-ppa_pkg::PORT_W){1'b0}}, clr_r} :
                            ppa_pkg::MARK_OOR};
        clr_nxt = clr_r + 16'd1;
        head_nxt = {16'd0, first_r};
        tail_nxt = pool_empty ? {16'd0, first_r} : {16'd0, last_r} + 32'd1;
      end
      ppa_pkg::ST_IDLE: begin
        func_nxt     = in_func;
        port_nxt     = in_port_number;
        pair_nxt     = in_want_pair;
        size_nxt     = span;
        iter_nxt     = '0;
        res_port_nxt = '0;
        res_ans_nxt  = 1'b0;
        res_fail_nxt = (in_func == ppa_pkg::FN_ALLOC) || (in_func == ppa_pkg::FN_ALLOC_EVEN);
        stat_req.addr = in_port_number;
      end
      ppa_pkg::ST_POP_CHK: ;
      ppa_pkg::ST_POP_RING: begin
        cand_nxt = ring_q;
        stat_req.addr = ring_q;
      end
      ppa_pkg::ST_POP_STAT: begin
        head_nxt = head_r + 32'd1;
        if (!ppa_pkg::taken_mark(stat_q) && stat_q == head_r) begin
          stat_req.we    = 1'b1;
          stat_req.wdata = ppa_pkg::MARK_SINGLE;
          if (func_r == ppa_pkg::FN_ALLOC) begin
            res_fail_nxt = 1'b0;
            res_port_nxt = cand_r;
          end
        end
      end
      ppa_pkg::ST_EVEN_NEXT: begin
        if (!cand_r[0] && !pair_r) begin
          res_fail_nxt = 1'b0;
          res_port_nxt = cand_r;
        end else if (!cand_r[0] && partner <= last_r) begin
          stat_req.addr = partner;
        end else begin
          // hand the port back at the tail
          stat_req.we = 1'b1;
          ring_req    = '{we: 1'b1, addr: tail_r[ppa_pkg::PORT_W-1:0], wdata: cand_r};
          tail_nxt    = tail_r + 32'd1;
          iter_nxt    = iter_r + 32'd1;
        end
      end
      ppa_pkg::ST_PAIR_STAT: begin
        if (stat_q == ppa_pkg::MARK_OOR || ppa_pkg::taken_mark(stat_q)) begin
          stat_req.we = 1'b1;
          ring_req    = '{we: 1'b1, addr: tail_r[ppa_pkg::PORT_W-1:0], wdata: cand_r};
          tail_nxt    = tail_r + 32'd1;
          iter_nxt    = iter_r + 32'd1;
        end else begin
          ring_req.addr = stat_q[ppa_pkg::PORT_W-1:0];
        end
      end
      ppa_pkg::ST_PAIR_RING: begin
        if (ring_q == partner) begin
          stat_req.we    = 1'b1;
          stat_req.wdata = ppa_pkg::MARK_EVEN;
        end else begin
          stat_req.we = 1'b1;
          ring_req    = '{we: 1'b1, addr: tail_r[ppa_pkg::PORT_W-1:0], wdata: cand_r};
          tail_nxt    = tail_r + 32'd1;
          iter_nxt    = iter_r + 32'd1;
        end
      end
      ppa_pkg::ST_PAIR_ODD: begin
        stat_req     = '{we: 1'b1, addr: partner, wdata: ppa_pkg::MARK_ODD};
        res_fail_nxt = 1'b0;
        res_port_nxt = cand_r;
      end
      ppa_pkg::ST_REL_STAT: begin
        if (in_pool(port_r, first_r, last_r) && ppa_pkg::taken_mark(stat_q)) begin
          stat_req = '{we: 1'b1, addr: port_r, wdata: tail_r};
          ring_req = '{we: 1'b1, addr: tail_r[ppa_pkg::PORT_W-1:0], wdata: port_r};
          tail_nxt = tail_r + 32'd1;
        end
      end
      ppa_pkg::ST_QRY_STAT: begin
        res_ans_nxt   = (func_r == ppa_pkg::FN_QRY_ALLOC) && ppa_pkg::taken_mark(stat_q);
        ring_req.addr = stat_q[ppa_pkg::PORT_W-1:0];
      end
      ppa_pkg::ST_QRY_RING: res_ans_nxt = (ring_q == port_r);
      ppa_pkg::ST_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oo_nxt = res_fail_r;
          op_nxt = res_port_r;
          oa_nxt = res_ans_r;
        end
      end
      default: ;
    endcase

    if (cfg_wr_en) begin
      clr_nxt = '0;
      if (cfg_index == ppa_pkg::REG_FIRST) begin
        first_nxt = cfg_wdata;
      end else begin
        last_nxt = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ppa_pkg::ST_CLEAR;
      first_r <= ppa_pkg::FIRST_RESET;
      last_r  <= ppa_pkg::LAST_RESET;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    size_r     <= size_nxt;
    iter_r     <= iter_nxt;
    func_r     <= func_nxt;
    port_r     <= port_nxt;
    pair_r     <= pair_nxt;
    cand_r     <= cand_nxt;
    res_fail_r <= res_fail_nxt;
    res_port_r <= res_port_nxt;
    res_ans_r  <= res_ans_nxt;
    oo_r       <= oo_nxt;
    op_r       <= op_nxt;
    oa_r       <= oa_nxt;
  end

  assign out_valid        = ov_r;
  assign out_outcome      = oo_r;
  assign out_granted_port = op_r;
  assign out_answer       = oa_r;

endmodule

// ----- hdl/port_pool_allocator.sv -----
// Port pool allocator. Allocate pops ring entries until one has a current status; release
// checks status and pushes a taken port back at the tail; queries read status, query available
// also the ring; allocate even pops up to (tail - head) ports, handing back odd or
// unpaired ones, refused at once if (tail - head) <= 1. One word in work at a time;
// the next is taken once the result is registered, later while out_stall holds it.
// Sync active-low reset and config writes (re)start clearing both RAMs, in_stall high.
`timescale 1ns / 1ps

module port_pool_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_port_number,
  input  logic        in_want_pair,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_outcome,
  output logic [15:0] out_granted_port,
  output logic        out_answer
);

  ppa_pkg::ring_req_t         ring_req;
  ppa_pkg::stat_req_t         stat_req;
  logic [ppa_pkg::PORT_W-1:0] ring_q;
  logic [ppa_pkg::STAT_W-1:0] stat_q;

  // sequencer: owns counters, config, the result word and the output register
  ppa_ctrl u_ctrl (
    .clk, .rst_n, .cfg_wr_en, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_func, .in_port_number, .in_want_pair,
    .out_valid, .out_stall, .out_outcome, .out_granted_port, .out_answer,
    .ring_req, .ring_q, .stat_req, .stat_q
  );

  // free ring: port numbers, addressed by counter mod 2^16
  ppa_ram #(.ADDR_W(ppa_pkg::PORT_W), .DATA_W(ppa_pkg::PORT_W)) u_ring (
    .clk, .we(ring_req.we), .addr(ring_req.addr), .wdata(ring_req.wdata), .rdata(ring_q)
  );

  // per-port status: push counter value or a mark
  ppa_ram #(.ADDR_W(ppa_pkg::PORT_W), .DATA_W(ppa_pkg::STAT_W)) u_status (
    .clk, .we(stat_req.we), .addr(stat_req.addr), .wdata(stat_req.wdata), .rdata(stat_q)
  );

endmodule

// ----- hdl/ppa_chk.sv -----
// ppa_chk: port-level checks of the allocator, bound to the top level.
// Depends only on the ports of port_pool_allocator.
`timescale 1ns / 1ps

module ppa_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_outcome,
  input logic [15:0] out_granted_port,
  input logic        out_answer
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_granted_port))
    else $error("stalled word changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_outcome |-> out_granted_port == 16'd0 && !out_answer)
    else $error("failed allocation carries data");

  a_ans_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_answer |-> !out_outcome && out_granted_port == 16'd0)
    else $error("query word carries grant");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_stall)
    else $error("not clearing after reset");

endmodule

bind port_pool_allocator ppa_chk u_ppa_chk (
  .clk, .rst_n, .in_stall, .out_valid, .out_stall, .out_outcome,
  .out_granted_port, .out_answer
);
